[hw/rtl/rx_buffer_watermark_flow_control_top_assert.svh]
// Assertion macros shared by the receive buffer RTL.
`ifndef RX_BUFFER_WATERMARK_FLOW_CONTROL_TOP_ASSERT_SVH
`define RX_BUFFER_WATERMARK_FLOW_CONTROL_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge.
`define RXWM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Antecedent this cycle, consequent in the next cycle.
`define RXWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RXWM_ASSERT(lbl, prop)
`define RXWM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/rxwm_pkg.sv]
// Types and codes shared by the receive buffer modules.
`timescale 1ns / 1ps

package rxwm_pkg;

  typedef enum logic [1:0] {
    OpDataIn   = 2'd0,
    OpStatIn   = 2'd1,
    OpDataTick = 2'd2,
    OpStatTick = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KindData     = 3'd0,
    KindStatus   = 3'd1,
    KindSlowDown = 3'd2,
    KindSpeedUp  = 3'd3,
    KindDataDrop = 3'd4,
    KindStatDrop = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    PaySrcReg  = 2'd0,
    PaySrcData = 2'd1,
    PaySrcStat = 2'd2
  } pay_src_e;

  localparam logic DestApp  = 1'b0;
  localparam logic DestLink = 1'b1;

endpackage

[hw/rtl/rxwm_fifo.sv]
// Circular FIFO with count, one write and one registered read per cycle.
`timescale 1ns / 1ps
`include "rx_buffer_watermark_flow_control_top_assert.svh"

module rxwm_fifo #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic                       pop_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic [$clog2(DEPTH+1)-1:0] count_o,
  output logic [WIDTH-1:0]           rdata_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int PtrW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [WIDTH-1:0] rdata_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  assign count_o = count_q;
  assign rdata_o = rdata_q;

  `RXWM_ASSERT(a_count_bound, count_q <= CntW'(DEPTH))
  `RXWM_ASSERT(a_no_push_full, push_i && !pop_i |-> count_q != CntW'(DEPTH))
  `RXWM_ASSERT(a_no_pop_empty, pop_i |-> count_q != '0)
  `RXWM_ASSERT_NEXT(a_push_counts, push_i && !pop_i, count_q == $past(count_q) + 1'b1)

endmodule

[hw/rtl/rx_buffer_watermark_flow_control_top.sv]
// A result appears in the cycle after its item is accepted, strobed by out_valid_o.
// Throughput: one item per cycle; busy stays low, the only stage is the result register.
// Popped payload comes from each FIFO's registered read port in that same result cycle.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset clears counts, pointers, slow-down flag; capacity becomes min(BUF_DEPTH, 256).
// FIFO storage is not cleared; entries are read only after being written.
`timescale 1ns / 1ps
`include "rx_buffer_watermark_flow_control_top_assert.svh"

module rx_buffer_watermark_flow_control_top #(
  parameter int BUF_DEPTH     = 256,
  parameter int STATUS_DEPTH  = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [$clog2(BUF_DEPTH+1)-1:0] cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     op_i,
  input  logic [PAYLOAD_WIDTH-1:0]       payload_i,
  output logic                           out_valid_o,
  output logic                           dest_o,
  output rxwm_pkg::kind_e                item_kind_o,
  output logic [PAYLOAD_WIDTH-1:0]       payload_out_o,
  output logic [$clog2(BUF_DEPTH+1)-1:0] occupancy_o
);

  import rxwm_pkg::*;

  localparam int CntW     = $clog2(BUF_DEPTH + 1);
  localparam int CmpW     = CntW + 3;
  localparam int StatCntW = $clog2(STATUS_DEPTH + 1);
  localparam int CapReset = (BUF_DEPTH < 256) ? BUF_DEPTH : 256;

  logic                     fire;
  logic [CntW-1:0]          cap_q, cap_eff;
  logic [CntW-1:0]          data_count;
  logic [StatCntW-1:0]      stat_count;
  logic [PAYLOAD_WIDTH-1:0] data_rdata, stat_rdata;
  logic                     data_push, data_pop, stat_push, stat_pop;
  logic                     data_full, wm_high, wm_low;
  logic                     slow_q, slow_d;
  logic                     valid_q, valid_d;
  logic                     dest_q, dest_d;
  kind_e                    kind_q, kind_d;
  pay_src_e                 src_q, src_d;
  logic [PAYLOAD_WIDTH-1:0] pay_q, pay_d;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign fire        = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CntW'(CapReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  assign cap_eff   = (cap_q > CntW'(BUF_DEPTH)) ? CntW'(BUF_DEPTH) : cap_q;
  assign data_full = data_count >= cap_eff;
  // 80% mark: 5*count >= 4*cap; 25% mark: 4*count < cap
  assign wm_high   = ((CmpW'(data_count) << 2) + CmpW'(data_count)) >= (CmpW'(cap_eff) << 2);
  assign wm_low    = (CmpW'(data_count) << 2) < CmpW'(cap_eff);

  always_comb begin
    data_push = 1'b0;
    data_pop  = 1'b0;
    stat_push = 1'b0;
    stat_pop  = 1'b0;
    slow_d    = slow_q;
    valid_d   = 1'b0;
    dest_d    = DestApp;
    kind_d    = KindData;
    src_d     = PaySrcReg;
    pay_d     = payload_i;
    if (fire) begin
      unique case (op_e'(op_i))
        OpDataIn: begin
          if (data_full) begin
            valid_d = 1'b1;
            kind_d  = KindDataDrop;
          end else begin
            data_push = 1'b1;
            if (wm_high && !slow_q) begin
              slow_d  = 1'b1;
              valid_d = 1'b1;
              dest_d  = DestLink;
              kind_d  = KindSlowDown;
              pay_d   = '0;
            end else if (wm_low && slow_q) begin
              slow_d  = 1'b0;
              valid_d = 1'b1;
              dest_d  = DestLink;
              kind_d  = KindSpeedUp;
              pay_d   = '0;
            end
          end
        end
        OpStatIn: begin
          if (stat_count == StatCntW'(STATUS_DEPTH)) begin
            valid_d = 1'b1;
            dest_d  = DestLink;
            kind_d  = KindStatDrop;
          end else begin
            stat_push = 1'b1;
          end
        end
        OpDataTick: begin
          if (data_count != '0) begin
            data_pop = 1'b1;
            valid_d  = 1'b1;
            src_d    = PaySrcData;
          end
        end
        OpStatTick: begin
          if (stat_count != '0) begin
            stat_pop = 1'b1;
            valid_d  = 1'b1;
            dest_d   = DestLink;
            kind_d   = KindStatus;
            src_d    = PaySrcStat;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      slow_q  <= slow_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dest_q <= dest_d;
    kind_q <= kind_d;
    src_q  <= src_d;
    pay_q  <= pay_d;
  end

  rxwm_fifo #(
    .DEPTH (BUF_DEPTH),
    .WIDTH (PAYLOAD_WIDTH)
  ) u_data_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (data_push),
    .pop_i   (data_pop),
    .wdata_i (payload_i),
    .count_o (data_count),
    .rdata_o (data_rdata)
  );

  rxwm_fifo #(
    .DEPTH (STATUS_DEPTH),
    .WIDTH (PAYLOAD_WIDTH)
  ) u_stat_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (stat_push),
    .pop_i   (stat_pop),
    .wdata_i (payload_i),
    .count_o (stat_count),
    .rdata_o (stat_rdata)
  );

  always_comb begin
    case (src_q)
      PaySrcData: payload_out_o = data_rdata;
      PaySrcStat: payload_out_o = stat_rdata;
      default:    payload_out_o = pay_q;
    endcase
  end

  assign out_valid_o = valid_q;
  assign dest_o      = dest_q;
  assign item_kind_o = kind_q;
  // count register already reflects the item being reported
  assign occupancy_o = data_count;

  `RXWM_ASSERT_NEXT(a_result_needs_item, !fire, !out_valid_o)
  `RXWM_ASSERT(a_slow_sets_flag, out_valid_o && item_kind_o == KindSlowDown |-> slow_q)
  `RXWM_ASSERT(a_fast_clears_flag, out_valid_o && item_kind_o == KindSpeedUp |-> !slow_q)
  `RXWM_ASSERT(a_push_below_cap, data_push |-> data_count < cap_eff)

endmodule
